/* rtl/core/hhpd_pkg.sv */
// Shared types and constants for the heading-hold PID drive unit.
// Register map codes, stop reason codes, reset values and pipeline stage records.
// No dependencies.
package hhpd_pkg;

    // Register indexes on the configuration port (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_KP_GAIN       = 3'd0,
        REG_KI_GAIN       = 3'd1,
        REG_KD_GAIN       = 3'd2,
        REG_TARGET_COUNTS = 3'd3,
        REG_RAMP_LIMIT    = 3'd4,
        REG_RAMP_STEP     = 3'd5,
        REG_POWER_LIMIT   = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        STOP_NONE     = 2'd0,
        STOP_DISTANCE = 2'd1,
        STOP_OBSTACLE = 2'd2
    } t_stop_reason;

    localparam logic [15:0] KP_GAIN_RST       = 16'd256;
    localparam logic [15:0] KI_GAIN_RST       = 16'd0;
    localparam logic [15:0] KD_GAIN_RST       = 16'd0;
    localparam logic [19:0] TARGET_COUNTS_RST = 20'd442;
    localparam logic [6:0]  RAMP_LIMIT_RST    = 7'd40;
    localparam logic [4:0]  RAMP_STEP_RST     = 5'd5;
    localparam logic [6:0]  POWER_LIMIT_RST   = 7'd45;

    localparam logic [6:0]  BASE_POWER_MAX    = 7'd127;

    // After the state update: error terms ready for the gain multiplies
    typedef struct packed {
        logic               run;
        t_stop_reason       reason;
        logic        [6:0]  base;
        logic signed [12:0] err;
        logic signed [23:0] isum;
        logic signed [13:0] derr;
    } t_s1;

    // After the multiplies
    typedef struct packed {
        logic               run;
        t_stop_reason       reason;
        logic        [6:0]  base;
        logic signed [29:0] p_kp;
        logic signed [40:0] p_ki;
        logic signed [30:0] p_kd;
    } t_s2;

endpackage

/* rtl/core/heading_hold_pid_drive_unit.sv */
// Heading-hold PID drive unit: top level, three-stage pipeline and APB register file.
// Depends on hhpd_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one control-period sample per beat:
//   start flag, heading error, forward motion, ramp tick and obstacle flag.
//   Output channel (o_valid / i_ready) returns one beat per sample: left and right
//   wheel power, running flag and stop reason.
//   Stage 1 updates run state, base power, distance, integral and error delta;
//   stage 2 forms the three gain products; stage 3 sums, scales by 1/4096 and
//   saturates each wheel to +-power_limit into the output register.
//   Results pass through the stage 1, stage 2 and output registers. Throughput is one
//   beat per cycle while i_ready stays high. Each stage holds when the one after it is
//   full and stalled, so up to three beats sit in flight while the receiver holds
//   i_ready low.
//   Reset clears the pipeline, returns the run state to idle with all state zero
//   and loads the default gains and limits. Write the APB registers only while
//   the pipeline is empty; pready is always high and reads return register values.
module heading_hold_pid_drive_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_start_run,
    input  logic signed [12:0] i_heading_error,
    input  logic signed [7:0]  i_motion_dy,
    input  logic               i_ramp_due,
    input  logic               i_obstacle,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [7:0]  o_left_power,
    output logic signed [7:0]  o_power_right,
    output logic               o_running,
    output logic [1:0]         o_stop_reason,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // configuration registers
    logic [15:0] r_kp_gain;
    logic [15:0] r_ki_gain;
    logic [15:0] r_kd_gain;
    logic [19:0] r_target_counts;
    logic [6:0]  r_ramp_limit;
    logic [4:0]  r_ramp_step;
    logic [6:0]  r_power_limit;

    // controller state
    logic [6:0]         r_base_power;
    logic signed [23:0] r_integral_sum;
    logic signed [12:0] r_previous_error;
    logic [23:0]        r_travelled;
    logic [23:0]        r_target_mark;
    logic               r_active;

    // pipeline
    logic             r_v1, r_v2, r_ov;
    hhpd_pkg::t_s1    r_s1, n_s1;
    hhpd_pkg::t_s2    r_s2, n_s2;
    logic signed [7:0] r_left_power, r_power_right;
    logic             r_running;
    logic [1:0]       r_stop_reason;

    logic en1, en2, en3, accept, cfg_wr;

    assign en3    = !r_ov || i_ready;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign accept = i_valid && en1;
    assign cfg_wr = psel && penable && pwrite;

    // ---------------- stage 1: run state and error terms ----------------
    logic [23:0]        target_sel, dist_left;
    logic               act, reached, ramp_now;
    logic [7:0]         base_sum;
    logic [6:0]         n_base_power;
    logic [23:0]        n_travelled;
    logic signed [24:0] isum_wide;
    logic signed [23:0] n_integral_sum;
    logic signed [13:0] derr;
    logic               n_active;
    logic               run_item;

    always_comb begin
        target_sel = i_start_run ? (r_travelled + {4'b0, r_target_counts}) : r_target_mark;
        act        = i_start_run || r_active;
        dist_left  = target_sel - r_travelled;
        reached    = dist_left[23] || (dist_left == 24'd0);

        ramp_now     = i_ramp_due && (r_base_power < r_ramp_limit);
        base_sum     = {1'b0, r_base_power} + {3'b0, r_ramp_step};
        n_base_power = base_sum[7] ? hhpd_pkg::BASE_POWER_MAX : base_sum[6:0];

        n_travelled = r_travelled + {{16{i_motion_dy[7]}}, i_motion_dy};

        isum_wide = {r_integral_sum[23], r_integral_sum}
                  + {{12{i_heading_error[12]}}, i_heading_error};
        if (i_heading_error == 13'sd0) begin
            n_integral_sum = 24'sd0;
        end else if (isum_wide[24] != isum_wide[23]) begin
            // saturate toward the sign of the true sum
            n_integral_sum = isum_wide[24] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
        end else begin
            n_integral_sum = isum_wide[23:0];
        end

        derr = {i_heading_error[12], i_heading_error}
             - {r_previous_error[12], r_previous_error};

        n_s1        = '0;
        n_active    = r_active;
        run_item    = 1'b0;
        if (!act) begin
            n_s1.reason = hhpd_pkg::STOP_NONE;
        end else if (i_obstacle) begin
            n_active    = 1'b0;
            n_s1.reason = hhpd_pkg::STOP_OBSTACLE;
        end else if (reached) begin
            n_active    = 1'b0;
            n_s1.reason = hhpd_pkg::STOP_DISTANCE;
        end else begin
            n_active    = 1'b1;
            run_item    = 1'b1;
            n_s1.run    = 1'b1;
            n_s1.reason = hhpd_pkg::STOP_NONE;
            n_s1.base   = ramp_now ? n_base_power : r_base_power;
            n_s1.err    = i_heading_error;
            n_s1.isum   = n_integral_sum;
            n_s1.derr   = derr;
        end
    end

    // ---------------- stage 2: gain products ----------------
    always_comb begin
        n_s2.run    = r_s1.run;
        n_s2.reason = r_s1.reason;
        n_s2.base   = r_s1.base;
        n_s2.p_kp   = $signed({1'b0, r_kp_gain}) * r_s1.err;
        n_s2.p_ki   = $signed({1'b0, r_ki_gain}) * r_s1.isum;
        n_s2.p_kd   = $signed({1'b0, r_kd_gain}) * r_s1.derr;
    end

    // ---------------- stage 3: sum, scale, saturate ----------------
    logic signed [42:0] pid_sum;
    logic signed [43:0] neg_sum;
    logic signed [31:0] corr;
    logic signed [32:0] left_raw, right_raw, lim_pos, lim_neg;
    logic signed [7:0]  n_left, n_right;

    always_comb begin
        pid_sum = {{13{r_s2.p_kp[29]}}, r_s2.p_kp}
                + {{2{r_s2.p_ki[40]}}, r_s2.p_ki}
                + {{12{r_s2.p_kd[30]}}, r_s2.p_kd};
        neg_sum = -{pid_sum[42], pid_sum};
        // arithmetic shift gives the floor of the quotient
        corr    = 32'(neg_sum >>> 12);

        left_raw  = $signed({26'd0, r_s2.base}) - {corr[31], corr};
        right_raw = $signed({26'd0, r_s2.base}) + {corr[31], corr};
        lim_pos   = $signed({26'd0, r_power_limit});
        lim_neg   = -lim_pos;

        if (left_raw > lim_pos) begin
            n_left = 8'(lim_pos);
        end else if (left_raw < lim_neg) begin
            n_left = 8'(lim_neg);
        end else begin
            n_left = 8'(left_raw);
        end

        if (right_raw > lim_pos) begin
            n_right = 8'(lim_pos);
        end else if (right_raw < lim_neg) begin
            n_right = 8'(lim_neg);
        end else begin
            n_right = 8'(right_raw);
        end

        if (!r_s2.run) begin
            n_left  = 8'sd0;
            n_right = 8'sd0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_gain        <= hhpd_pkg::KP_GAIN_RST;
            r_ki_gain        <= hhpd_pkg::KI_GAIN_RST;
            r_kd_gain        <= hhpd_pkg::KD_GAIN_RST;
            r_target_counts  <= hhpd_pkg::TARGET_COUNTS_RST;
            r_ramp_limit     <= hhpd_pkg::RAMP_LIMIT_RST;
            r_ramp_step      <= hhpd_pkg::RAMP_STEP_RST;
            r_power_limit    <= hhpd_pkg::POWER_LIMIT_RST;
            r_base_power     <= '0;
            r_integral_sum   <= '0;
            r_previous_error <= '0;
            r_travelled      <= '0;
            r_target_mark    <= '0;
            r_active         <= 1'b0;
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_ov             <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (hhpd_pkg::t_reg_idx'(paddr[4:2]))
                    hhpd_pkg::REG_KP_GAIN:       r_kp_gain       <= pwdata[15:0];
                    hhpd_pkg::REG_KI_GAIN:       r_ki_gain       <= pwdata[15:0];
                    hhpd_pkg::REG_KD_GAIN:       r_kd_gain       <= pwdata[15:0];
                    hhpd_pkg::REG_TARGET_COUNTS: r_target_counts <= pwdata[19:0];
                    hhpd_pkg::REG_RAMP_LIMIT:    r_ramp_limit    <= pwdata[6:0];
                    hhpd_pkg::REG_RAMP_STEP:     r_ramp_step     <= pwdata[4:0];
                    hhpd_pkg::REG_POWER_LIMIT:   r_power_limit   <= pwdata[6:0];
                    default: ;
                endcase
            end

            if (accept) begin
                if (i_start_run) begin
                    r_target_mark <= target_sel;
                end
                r_active <= n_active;
                if (run_item) begin
                    r_base_power     <= n_s1.base;
                    r_travelled      <= n_travelled;
                    r_integral_sum   <= n_integral_sum;
                    r_previous_error <= i_heading_error;
                end
            end

            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_ov <= r_v2;
            end
        end
    end

    // payload stages, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (en2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (en3 && r_v2) begin
            r_left_power  <= n_left;
            r_power_right <= n_right;
            r_running     <= r_s2.run;
            r_stop_reason <= r_s2.reason;
        end
    end

    // register readback
    always_comb begin
        unique case (hhpd_pkg::t_reg_idx'(paddr[4:2]))
            hhpd_pkg::REG_KP_GAIN:       prdata = {16'd0, r_kp_gain};
            hhpd_pkg::REG_KI_GAIN:       prdata = {16'd0, r_ki_gain};
            hhpd_pkg::REG_KD_GAIN:       prdata = {16'd0, r_kd_gain};
            hhpd_pkg::REG_TARGET_COUNTS: prdata = {12'd0, r_target_counts};
            hhpd_pkg::REG_RAMP_LIMIT:    prdata = {25'd0, r_ramp_limit};
            hhpd_pkg::REG_RAMP_STEP:     prdata = {27'd0, r_ramp_step};
            hhpd_pkg::REG_POWER_LIMIT:   prdata = {25'd0, r_power_limit};
            default:                     prdata = 32'd0;
        endcase
    end

    assign pready        = 1'b1;
    assign o_ready       = en1;
    assign o_valid       = r_ov;
    assign o_left_power  = r_left_power;
    assign o_power_right = r_power_right;
    assign o_running     = r_running;
    assign o_stop_reason = r_stop_reason;

endmodule

/* test/heading_hold_pid_drive_unit_tb.sv */
// Self-checking testbench for heading_hold_pid_drive_unit: directed samples, random drive
// runs over several register settings and a sustained-error hold, checked beat by beat.
// Depends on hhpd_pkg and the heading_hold_pid_drive_unit RTL.
module heading_hold_pid_drive_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic               start;
        logic signed [12:0] herr;
        logic signed [7:0]  dy;
        logic               ramp;
        logic               obstacle;
    } t_sample;

    typedef struct packed {
        logic signed [7:0]      left;
        logic signed [7:0]      right;
        logic                   running;
        hhpd_pkg::t_stop_reason reason;
    } t_drive_result;

    class wheel_power_scoreboard;
        bit [15:0] kp, ki, kd;
        bit [19:0] target_counts;
        bit [6:0]  ramp_limit;
        bit [4:0]  ramp_step;
        bit [6:0]  power_limit;

        int        base_power;
        longint    integral_sum;
        longint    last_error;
        bit [23:0] travelled;
        bit [23:0] target_mark;
        bit        active;

        t_drive_result expected_drive[$];
        int errors;

        function new();
            kp = hhpd_pkg::KP_GAIN_RST;
            ki = hhpd_pkg::KI_GAIN_RST;
            kd = hhpd_pkg::KD_GAIN_RST;
            target_counts = hhpd_pkg::TARGET_COUNTS_RST;
            ramp_limit = hhpd_pkg::RAMP_LIMIT_RST;
            ramp_step = hhpd_pkg::RAMP_STEP_RST;
            power_limit = hhpd_pkg::POWER_LIMIT_RST;
            base_power = 0;
            integral_sum = 0;
            last_error = 0;
            travelled = '0;
            target_mark = '0;
            active = 1'b0;
            errors = 0;
        endfunction

        function void set_register(hhpd_pkg::t_reg_idx idx, bit [31:0] value);
            case (idx)
                hhpd_pkg::REG_KP_GAIN:       kp = value[15:0];
                hhpd_pkg::REG_KI_GAIN:       ki = value[15:0];
                hhpd_pkg::REG_KD_GAIN:       kd = value[15:0];
                hhpd_pkg::REG_TARGET_COUNTS: target_counts = value[19:0];
                hhpd_pkg::REG_RAMP_LIMIT:    ramp_limit = value[6:0];
                hhpd_pkg::REG_RAMP_STEP:     ramp_step = value[4:0];
                hhpd_pkg::REG_POWER_LIMIT:   power_limit = value[6:0];
                default: ;
            endcase
        endfunction

        function longint clamp_power(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function void note_sample(t_sample s);
            t_drive_result r;
            bit [23:0] gap;
            longint e, d, isum, pid_sum, corr, lim;
            int next_base;
            r = '{left: '0, right: '0, running: 1'b0, reason: hhpd_pkg::STOP_NONE};
            if (s.start) begin
                target_mark = travelled + 24'(target_counts);
                active = 1'b1;
            end
            gap = target_mark - travelled;
            if (!active) begin
                // idle: zeros, state untouched
            end else if (s.obstacle) begin
                active = 1'b0;
                r.reason = hhpd_pkg::STOP_OBSTACLE;
            end else if ($signed(gap) <= 0) begin
                active = 1'b0;
                r.reason = hhpd_pkg::STOP_DISTANCE;
            end else begin
                if (s.ramp && base_power < int'(ramp_limit)) begin
                    next_base = base_power + int'(ramp_step);
                    base_power = (next_base > int'(hhpd_pkg::BASE_POWER_MAX)) ?
                                 int'(hhpd_pkg::BASE_POWER_MAX) : next_base;
                end
                travelled = travelled + {{16{s.dy[7]}}, s.dy};
                e = longint'(s.herr);
                if (e == 0) begin
                    integral_sum = 0;
                end else begin
                    isum = integral_sum + e;
                    if (isum > 64'sd8388607) isum = 64'sd8388607;
                    if (isum < -64'sd8388608) isum = -64'sd8388608;
                    integral_sum = isum;
                end
                d = e - last_error;
                pid_sum = longint'(kp) * e + longint'(ki) * integral_sum + longint'(kd) * d;
                // floor of the negated sum over 4096
                corr = (-pid_sum) >>> 12;
                lim = longint'(power_limit);
                last_error = e;
                r.left = 8'(clamp_power(longint'(base_power) - corr, lim));
                r.right = 8'(clamp_power(longint'(base_power) + corr, lim));
                r.running = 1'b1;
            end
            expected_drive.push_back(r);
        endfunction

        function void check_drive(t_drive_result got);
            t_drive_result want;
            if (expected_drive.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = expected_drive.pop_front();
            if (got.left !== want.left) begin
                $error("left_power expected %0d actual %0d", want.left, got.left);
                errors++;
            end
            if (got.right !== want.right) begin
                $error("power_right expected %0d actual %0d", want.right, got.right);
                errors++;
            end
            if (got.running !== want.running) begin
                $error("running expected %0d actual %0d", want.running, got.running);
                errors++;
            end
            if (got.reason !== want.reason) begin
                $error("stop_reason expected %0d actual %0d", want.reason, got.reason);
                errors++;
            end
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_start_run = 1'b0;
    logic signed [12:0] i_heading_error = '0;
    logic signed [7:0]  i_motion_dy = '0;
    logic               i_ramp_due = 1'b0;
    logic               i_obstacle = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [7:0]  o_left_power;
    logic signed [7:0]  o_power_right;
    logic               o_running;
    logic [1:0]         o_stop_reason;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    wheel_power_scoreboard sb = new();
    bit quiet = 1'b0;
    int cycle_count = 0;

    heading_hold_pid_drive_unit dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check on handshake, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_drive('{left: o_left_power, right: o_power_right,
                             running: o_running,
                             reason: hhpd_pkg::t_stop_reason'(o_stop_reason)});
        i_ready <= quiet || ($urandom_range(99) >= 37);
    end

    task automatic send_sample(input t_sample s);
        while (!quiet && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_run <= s.start;
        i_heading_error <= s.herr;
        i_motion_dy <= s.dy;
        i_ramp_due <= s.ramp;
        i_obstacle <= s.obstacle;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(s);
    endtask

    task automatic write_register(input hhpd_pkg::t_reg_idx idx, input bit [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // drop valid so the last beat is not taken again, then wait for the pipeline to empty
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_phase(input bit [15:0] kp, input bit [15:0] ki,
                                 input bit [15:0] kd, input bit [19:0] tc,
                                 input bit [6:0] rl, input bit [4:0] rs,
                                 input bit [6:0] pl);
        drain_results();
        write_register(hhpd_pkg::REG_KP_GAIN, 32'(kp));
        write_register(hhpd_pkg::REG_KI_GAIN, 32'(ki));
        write_register(hhpd_pkg::REG_KD_GAIN, 32'(kd));
        write_register(hhpd_pkg::REG_TARGET_COUNTS, 32'(tc));
        write_register(hhpd_pkg::REG_RAMP_LIMIT, 32'(rl));
        write_register(hhpd_pkg::REG_RAMP_STEP, 32'(rs));
        write_register(hhpd_pkg::REG_POWER_LIMIT, 32'(pl));
    endtask

    function automatic t_sample make_sample(bit start, int herr, int dy, bit ramp, bit obs);
        t_sample s;
        s.start = start;
        s.herr = 13'(herr);
        s.dy = 8'(dy);
        s.ramp = ramp;
        s.obstacle = obs;
        return s;
    endfunction

    function automatic int random_error();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 0;
        if (roll < 40) return $urandom_range(64) - 32;
        return $urandom_range(5760) - 2880;
    endfunction

    function automatic t_sample run_sample();
        int dy;
        dy = ($urandom_range(99) < 80) ? $urandom_range(60) : $urandom_range(255) - 128;
        return make_sample($urandom_range(99) < 2, random_error(), dy,
                           1'($urandom_range(1)), $urandom_range(99) < 2);
    endfunction

    function automatic t_sample noise_sample();
        return make_sample($urandom_range(99) < 30, $urandom_range(5760) - 2880,
                           $urandom_range(255) - 128, 1'($urandom_range(1)),
                           1'($urandom_range(1)));
    endfunction

    // well-formed runs with random content, with some noise in between
    task automatic random_traffic(input int item_goal);
        int sent;
        int run_len;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(99) < 80) begin
                send_sample(make_sample(1'b1, random_error(), $urandom_range(60),
                                        1'($urandom_range(1)), $urandom_range(99) < 3));
                sent++;
                run_len = $urandom_range(40, 5);
                while (sb.active && run_len > 0) begin
                    send_sample(run_sample());
                    sent++;
                    run_len--;
                end
            end else begin
                send_sample(noise_sample());
                if (sb.active) sent++;
            end
        end
    endtask

    task automatic random_phase();
        program_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      16'($urandom_range(65535)), 20'($urandom_range(3000)),
                      7'($urandom_range(100)), 5'($urandom_range(20)),
                      7'($urandom_range(100)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on the reset settings
        send_sample(make_sample(1'b0, 2880, 127, 1'b1, 1'b1));    // idle: zeros
        send_sample(make_sample(1'b0, -2880, -128, 1'b0, 1'b0));
        send_sample(make_sample(1'b1, 100, 5, 1'b1, 1'b1));       // start into obstacle
        send_sample(make_sample(1'b1, 0, 0, 1'b1, 1'b0));         // zero error clears sum
        send_sample(make_sample(1'b0, 2880, 127, 1'b1, 1'b0));
        send_sample(make_sample(1'b0, -2880, -128, 1'b1, 1'b0));
        send_sample(make_sample(1'b0, 1, 127, 1'b1, 1'b0));
        send_sample(make_sample(1'b0, -1, 127, 1'b1, 1'b0));
        send_sample(make_sample(1'b0, -17, 127, 1'b1, 1'b0));
        send_sample(make_sample(1'b0, 33, 127, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 0, 127, 1'b1, 1'b1));       // distance and obstacle
        send_sample(make_sample(1'b0, 5, 3, 1'b1, 1'b0));         // idle after stop
        send_sample(make_sample(1'b1, 16, 127, 1'b1, 1'b0));      // restart, state carries
        send_sample(make_sample(1'b0, -16, 127, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 2000, 127, 1'b1, 1'b0));
        send_sample(make_sample(1'b0, -2000, 127, 1'b1, 1'b0));
        send_sample(make_sample(1'b0, 7, 0, 1'b0, 1'b0));         // distance stop
        send_sample(make_sample(1'b0, 7, 0, 1'b0, 1'b0));

        program_phase(16'd0, 16'd0, 16'd0, 20'd0, 7'd0, 5'd0, 7'd0);
        send_sample(make_sample(1'b1, 2880, 10, 1'b1, 1'b0));     // zero target stops at once
        send_sample(make_sample(1'b0, 2880, 10, 1'b1, 1'b0));
        program_phase(16'd256, 16'd64, 16'd512, 20'd2000, 7'd7, 5'd20, 7'd100);
        send_sample(make_sample(1'b1, 300, 1, 1'b1, 1'b0));       // base above limit, no ramp
        send_sample(make_sample(1'b0, -300, 1, 1'b1, 1'b0));
        send_sample(make_sample(1'b0, 300, 1, 1'b1, 1'b1));

        // random part over several settings
        program_phase(hhpd_pkg::KP_GAIN_RST, hhpd_pkg::KI_GAIN_RST, hhpd_pkg::KD_GAIN_RST,
                      hhpd_pkg::TARGET_COUNTS_RST, hhpd_pkg::RAMP_LIMIT_RST,
                      hhpd_pkg::RAMP_STEP_RST, hhpd_pkg::POWER_LIMIT_RST);
        random_traffic(90);
        program_phase(16'($urandom_range(2048)), 16'($urandom_range(256)),
                      16'($urandom_range(2048)), 20'($urandom_range(3000, 200)),
                      7'($urandom_range(100)), 5'($urandom_range(20)),
                      7'($urandom_range(100)));
        random_traffic(90);
        program_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 7'd100, 5'd20, 7'd100);
        random_traffic(90);
        program_phase(16'd0, 16'd0, 16'd0, 20'd0, 7'd0, 5'd0, 7'd0);
        random_traffic(30);
        random_phase();
        quiet = 1'b1;
        random_traffic(90);
        drain_results();
        quiet = 1'b0;
        random_phase();
        random_traffic(90);
        random_phase();
        random_traffic(90);
        random_phase();
        random_traffic(90);

        // hold a large error under full integral gain to drive the widest integral product
        program_phase(16'd0, 16'hFFFF, 16'd0, 20'hFFFFF, 7'd100, 5'd20, 7'd100);
        send_sample(make_sample(1'b1, 2880, 0, 1'b1, 1'b0));
        repeat (12) send_sample(make_sample(1'b0, 2880, 0, 1'($urandom_range(1)), 1'b0));
        repeat (12) send_sample(make_sample(1'b0, -2880, 0, 1'($urandom_range(1)), 1'b0));
        send_sample(make_sample(1'b0, 0, 0, 1'b0, 1'b1));

        drain_results();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
